FILE: design/mrf_pkg.sv
package mrf_pkg;

  // frame status codes
  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  // crc-16 (reflected) constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // function codes and the exception bit
  localparam logic [7:0] FC_EXC_BIT   = 8'h80;
  localparam logic [7:0] FC_WR_COIL   = 8'h05;
  localparam logic [7:0] FC_WR_REG    = 8'h06;
  localparam logic [7:0] FC_EXC_STAT  = 8'h07;
  localparam logic [7:0] FC_WR_COILS  = 8'h0F;
  localparam logic [7:0] FC_WR_REGS   = 8'h10;
  localparam logic [7:0] FC_RD_FIRST  = 8'h01;
  localparam logic [7:0] FC_RD_LAST   = 8'h04;
  localparam logic [7:0] FC_SLAVE_ID  = 8'h11;

  // fixed frame lengths
  localparam logic [8:0] LEN_SHORT = 9'd5;
  localparam logic [8:0] LEN_WRITE = 9'd8;

  // one result word
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [1:0] frame_status;
    logic [8:0] frame_length;
  } mrf_result_t;

  // codes whose length follows from the byte-count field
  function automatic logic counted_code(input logic [7:0] fc);
    counted_code = ((fc >= FC_RD_FIRST) && (fc <= FC_RD_LAST)) || (fc == FC_SLAVE_ID);
  endfunction

endpackage

FILE: design/mrf_if.sv
interface mrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [1:0] frame_status;
  logic [8:0] frame_length;

  modport source (output valid, output data_byte, output byte_index,
                  output frame_status, output frame_length, input ready);
  modport sink   (input valid, input data_byte, input byte_index,
                  input frame_status, input frame_length, output ready);
endinterface

FILE: design/mrf_crc.sv
module mrf_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);
  import mrf_pkg::*;

  // eight shift-and-xor steps of the reflected crc, unrolled
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

FILE: design/mrf_frame.sv
module mrf_frame #(
  parameter int MAX_FRAME = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [7:0]         rx_byte,
  output mrf_pkg::mrf_result_t result
);
  import mrf_pkg::*;

  localparam logic [8:0] MaxLen = 9'(MAX_FRAME);

  // frame state
  logic [8:0]  byte_count, byte_count_next;
  logic [7:0]  function_code, function_code_next;
  logic [8:0]  expected_length, expected_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_low, received_crc_low_next;

  logic [15:0] crc_upd;

  mrf_crc u_crc (
    .crc_in  (running_crc),
    .data    (rx_byte),
    .crc_out (crc_upd)
  );

  // decode, crc step and status for the byte in hand
  always_comb begin
    logic [8:0]  el;
    logic [7:0]  fc;
    logic        unknown;
    logic        clear;
    logic [15:0] crc_n;
    logic [7:0]  low_n;
    logic [8:0]  idx_p1;
    logic [9:0]  idx_p2;

    el      = expected_length;
    fc      = function_code;
    unknown = 1'b0;
    clear   = 1'b0;
    crc_n   = running_crc;
    low_n   = received_crc_low;
    idx_p1  = byte_count + 9'd1;
    idx_p2  = {1'b0, byte_count} + 10'd2;

    result.data_byte    = rx_byte;
    result.byte_index   = byte_count[7:0];
    result.frame_status = ST_PENDING;
    result.frame_length = 9'd0;
    byte_count_next     = idx_p1;

    if (byte_count >= MaxLen) begin
      // position past the largest frame
      result.byte_index   = 8'd0;
      result.frame_status = ST_BAD;
      clear               = 1'b1;
    end else begin
      // length decode from the function code or byte count
      if (byte_count == 9'd1) begin
        fc = rx_byte;
        if ((rx_byte & FC_EXC_BIT) != 8'h00) begin
          el = LEN_SHORT;
        end else if (rx_byte == FC_WR_COIL || rx_byte == FC_WR_REG ||
                     rx_byte == FC_WR_COILS || rx_byte == FC_WR_REGS) begin
          el = LEN_WRITE;
        end else if (rx_byte == FC_EXC_STAT) begin
          el = LEN_SHORT;
        end else if (!counted_code(rx_byte)) begin
          unknown = 1'b1;
        end
      end else if (byte_count == 9'd2 && expected_length == 9'd0 &&
                   counted_code(function_code)) begin
        el = LEN_SHORT + {1'b0, rx_byte};
      end

      priority if (unknown) begin
        result.frame_status = ST_BAD;
        clear               = 1'b1;
      end else if (el > MaxLen) begin
        result.frame_status = ST_BAD;
        result.frame_length = el;
        clear               = 1'b1;
      end else begin
        // crc over payload, capture of the low crc byte
        if (el == 9'd0 || idx_p2 < {1'b0, el}) begin
          crc_n = crc_upd;
        end else if (idx_p2 == {1'b0, el}) begin
          low_n = rx_byte;
        end
        result.frame_length = el;
        if (el != 9'd0 && idx_p1 == el) begin
          result.frame_status = ({rx_byte, received_crc_low} == crc_n) ? ST_DONE : ST_BAD;
          clear               = 1'b1;
        end
      end
    end

    function_code_next    = fc;
    expected_length_next  = el;
    running_crc_next      = crc_n;
    received_crc_low_next = low_n;
    if (clear) begin
      byte_count_next       = 9'd0;
      function_code_next    = 8'd0;
      expected_length_next  = 9'd0;
      running_crc_next      = CRC_INIT;
      received_crc_low_next = 8'd0;
    end
  end

  // state update as the byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= 9'd0;
      function_code    <= 8'd0;
      expected_length  <= 9'd0;
      running_crc      <= CRC_INIT;
      received_crc_low <= 8'd0;
    end else if (advance) begin
      byte_count       <= byte_count_next;
      function_code    <= function_code_next;
      expected_length  <= expected_length_next;
      running_crc      <= running_crc_next;
      received_crc_low <= received_crc_low_next;
    end
  end

endmodule

FILE: design/modbus_rtu_response_framer_unit.sv
// modbus rtu response framer
// rx carries one response byte per word; tx carries one result word for
// every byte: the echoed byte, its index in the frame, the frame status
// (pending, complete with good crc, malformed) and the expected length.
// both channels use a valid/ready handshake; a word moves when both are high.
// an accepted byte passes through the input register and then the result
// register, from which it is offered on tx.
// throughput: one byte per cycle while tx does not stall; the crc step and
// length decode are combinational between the input and result registers.
// when tx stalls, the result register holds its word and the input register
// still takes one more byte; rx.ready drops only when both are full.
// reset empties both registers and returns the frame state to the start of
// a frame with the crc preset to all ones.
module modbus_rtu_response_framer_unit #(
  parameter int MAX_FRAME = 256
) (
  input logic      clk,
  input logic      rst,
  mrf_in_if.sink   rx,
  mrf_out_if.source tx
);
  import mrf_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        tx_valid;
  mrf_result_t tx_word;
  mrf_result_t result;
  logic        load;
  logic        advance;

  assign load     = !tx_valid || tx.ready;
  assign advance  = s1_valid && load;
  assign rx.ready = !s1_valid || load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  mrf_frame #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (s1_byte),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (load) begin
      tx_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_word <= result;
    end
  end

  assign tx.valid        = tx_valid;
  assign tx.data_byte    = tx_word.data_byte;
  assign tx.byte_index   = tx_word.byte_index;
  assign tx.frame_status = tx_word.frame_status;
  assign tx.frame_length = tx_word.frame_length;

endmodule

FILE: design/mrf_checker.sv
module mrf_checker (
  input logic       clk,
  input logic       rst,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] byte_index,
  input logic [1:0] frame_status,
  input logic [8:0] frame_length
);
  import mrf_pkg::*;

  // index expected on the next result word
  logic [7:0] next_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_index <= 8'd0;
    end else if (tx_valid && tx_ready) begin
      if (frame_status == ST_PENDING) begin
        next_index <= byte_index + 8'd1;
      end else begin
        next_index <= 8'd0;
      end
    end
  end

  // a stalled result word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(byte_index) && $stable(frame_status))
    else $error("result word dropped while stalled");

  // indices run on from the last word and restart after a frame ends
  a_index: assert property (@(posedge clk) disable iff (rst)
    tx_valid |-> byte_index == next_index)
    else $error("byte index out of sequence");

  // a complete frame ends on its last byte
  a_done: assert property (@(posedge clk) disable iff (rst)
    tx_valid && frame_status == ST_DONE |->
      frame_length != 9'd0 && {1'b0, byte_index} == frame_length - 9'd1)
    else $error("complete status away from frame end");

  // first byte of a frame is always pending with no length
  a_first: assert property (@(posedge clk) disable iff (rst)
    tx_valid && byte_index == 8'd0 |->
      frame_status == ST_PENDING && frame_length == 9'd0)
    else $error("bad status on first byte");

  // status codes stay within range
  a_status: assert property (@(posedge clk) disable iff (rst)
    tx_valid |-> frame_status == ST_PENDING || frame_status == ST_DONE ||
                 frame_status == ST_BAD)
    else $error("frame status code out of range");

endmodule

bind modbus_rtu_response_framer_unit mrf_checker u_mrf_checker (
  .clk          (clk),
  .rst          (rst),
  .tx_valid     (tx.valid),
  .tx_ready     (tx.ready),
  .byte_index   (tx.byte_index),
  .frame_status (tx.frame_status),
  .frame_length (tx.frame_length)
);
